// ----- rtl/rstd_pkg.sv -----
// ============================================================================
// Radix string to decimal text: shared package
// Payload types, widths, character codes and small helper functions.
// ============================================================================
`default_nettype none

package rstd_pkg;

    // Integer part width.
    localparam int IntBits = 32;
    // Largest number of fraction input digits that are kept.
    localparam int FracInDigits = 12;
    // Largest number of fraction output digits.
    localparam int FracOutDigits = 20;
    // Width of the fraction numerator and denominator.
    localparam int FracBits = 64;
    // Width of the fraction digit counter.
    localparam int FcntBits = 4;
    // Width of the output fraction digit counter.
    localparam int OcntBits = 5;
    // Width of the integer digit counter.
    localparam int DcntBits = 5;
    // Register reset value for the radix.
    localparam logic [5:0] BaseReset = 6'd10;

    // Character codes.
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChA     = 8'h41;
    localparam logic [7:0] ChZ     = 8'h5A;

    // One input item.
    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_number;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
        logic       overflow;
    } t_out_item;

    // A classified item handed from the front part to the back part.
    typedef struct packed {
        logic       is_sep;
        logic [5:0] digit;
        logic       last;
    } t_cmd;

    // Digit value of one character; anything else is zero.
    function automatic logic [5:0] digit_value(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'd0;
        if (ch >= ChZero && ch <= ChNine) begin
            t = ch - ChZero;
        end else if (ch >= ChA && ch <= ChZ) begin
            t = ch - ChA + 8'd10;
        end
        return t[5:0];
    endfunction

    // Radix clamped to the range 2 to 36.
    function automatic logic [5:0] eff_base(input logic [5:0] b);
        logic [5:0] r;
        r = b;
        if (b < 6'd2) begin
            r = 6'd2;
        end else if (b > 6'd36) begin
            r = 6'd36;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rstd_front.sv -----
// ============================================================================
// Radix string to decimal text: front part
// Accepts characters, classifies them and keeps a two-entry queue of
// classified items for the back part.
// ============================================================================
`default_nettype none

module rstd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rstd_pkg::t_in_item i_item,
    output logic                   o_stall,
    output logic                   o_cmd_valid,
    output rstd_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_take
);

    rstd_pkg::t_cmd r_q0, r_q1, n_q0, n_q1;
    logic [1:0]     r_cnt, n_cnt;
    rstd_pkg::t_cmd w_new;
    logic           w_push;

    // Classify the incoming character.
    always_comb begin
        w_new.is_sep = (i_item.symbol == rstd_pkg::ChDot) ||
                       (i_item.symbol == rstd_pkg::ChComma);
        w_new.digit  = rstd_pkg::digit_value(i_item.symbol);
        w_new.last   = i_item.end_of_number;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q0;

    // Queue update: pop from the head, push at the tail.
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        if (i_cmd_take) begin
            n_q0  = r_q1;
            n_cnt = n_cnt - 2'd1;
        end
        if (w_push) begin
            if (n_cnt == 2'd0) begin
                n_q0 = w_new;
            end else begin
                n_q1 = w_new;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

`default_nettype wire

// ----- rtl/rstd_back.sv -----
// ============================================================================
// Radix string to decimal text: back part
// Updates the number state per item and, on the last character, emits
// the integer digits and the fraction digits one step at a time.
// ============================================================================
`default_nettype none

module rstd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [5:0]         i_base,
    input  wire logic               i_cmd_valid,
    input  wire rstd_pkg::t_cmd     i_cmd,
    output logic                    o_cmd_take,
    output logic                    o_valid,
    output rstd_pkg::t_out_item     o_item,
    input  wire logic               i_stall
);

    localparam int IB = rstd_pkg::IntBits;
    localparam int FB = rstd_pkg::FracBits;
    // Reciprocal of ten for a 32-bit integer part: q = (x * Recip10) >> 35.
    localparam logic [IB-1:0] Recip10 = 32'hCCCC_CCCD;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ACC  = 7'b0000010,
        S_IDIV = 7'b0000100,
        S_IOUT = 7'b0001000,
        S_DOT  = 7'b0010000,
        S_FDIV = 7'b0100000,
        S_FOUT = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    rstd_pkg::t_cmd  r_cmd;
    logic [IB-1:0]   r_int;
    logic            r_infrac;
    logic [FB-1:0]   r_num, r_den;
    logic [rstd_pkg::FcntBits-1:0] r_fcnt;
    logic            r_ovf;
    // Decimal digits of the integer part, least significant first.
    logic [3:0]      r_digs [20];
    logic [rstd_pkg::DcntBits-1:0] r_nd;
    logic [rstd_pkg::OcntBits-1:0] r_nf;
    logic [IB-1:0]   r_quo;
    logic [2*IB-1:0] r_prod;
    logic [3:0]      r_j;
    logic [FB:0]     r_t;
    logic [3:0]      r_q;
    logic            r_oval;
    rstd_pkg::t_out_item r_oitem;

    logic            w_out_free;
    logic            w_emit;
    logic [5:0]      w_b;
    logic [IB+5:0]   w_prod;
    logic [IB-1:0]   w_mask;
    logic [IB-1:0]   w_q10;
    logic [IB-1:0]   w_rem;
    logic [FB:0]     w_tsum;
    logic [FB:0]     w_tnext;

    assign w_out_free = !r_oval || !i_stall;
    assign w_emit     = ((r_state == S_DOT) || (r_state == S_FOUT)) && w_out_free;
    assign o_valid    = r_oval;
    assign o_item     = r_oitem;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign w_b        = rstd_pkg::eff_base(i_base);
    assign w_mask     = '1;
    assign w_prod     = r_int * w_b + {{IB{1'b0}}, r_cmd.digit};
    assign w_q10      = IB'(r_prod[2*IB-1:35]);
    assign w_rem      = r_quo - ((w_q10 << 3) + (w_q10 << 1));
    assign w_tsum     = r_t + {1'b0, r_num};
    assign w_tnext    = (w_tsum >= {1'b0, r_den}) ? w_tsum - {1'b0, r_den} : w_tsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oval   <= 1'b0;
            r_int    <= '0;
            r_infrac <= 1'b0;
            r_num    <= '0;
            r_den    <= {{(FB-1){1'b0}}, 1'b1};
            r_fcnt   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            // The output register fills on an emit and empties when taken.
            if (w_emit) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                // Take one classified item.
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_ACC;
                    end
                end
                // Update the number state.
                S_ACC: begin
                    if (r_cmd.is_sep) begin
                        r_infrac <= 1'b1;
                    end else if (!r_infrac) begin
                        if (w_prod[IB+5:IB] != '0) begin
                            r_ovf <= 1'b1;
                        end
                        r_int <= w_prod[IB-1:0] & w_mask;
                    end else if (r_fcnt < rstd_pkg::FcntBits'(rstd_pkg::FracInDigits)) begin
                        r_num  <= r_num * FB'(w_b) + FB'(r_cmd.digit);
                        r_den  <= r_den * FB'(w_b);
                        r_fcnt <= r_fcnt + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (r_cmd.last) begin
                        r_nd    <= '0;
                        r_state <= S_IDIV;
                        r_quo   <= r_cmd.is_sep || r_infrac ? r_int : w_prod[IB-1:0];
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // Multiply by the reciprocal of ten.
                S_IDIV: begin
                    r_prod  <= r_quo * Recip10;
                    r_state <= S_IOUT;
                end
                // Store one digit; continue while the quotient is nonzero.
                S_IOUT: begin
                    r_digs[r_nd] <= w_rem[3:0];
                    r_nd         <= r_nd + 1'b1;
                    r_quo        <= w_q10;
                    if (w_q10 != '0 && r_nd != 5'd19) begin
                        r_state <= S_IDIV;
                    end else begin
                        r_state <= S_DOT;
                    end
                end
                // Emit integer digits, most significant first, then the point if any fraction digits were kept.
                S_DOT: begin
                    if (w_out_free) begin
                        r_oitem.overflow <= r_ovf;
                        if (r_nd != '0) begin
                            r_oitem.text_char   <= rstd_pkg::ChZero + 8'(r_digs[r_nd-1'b1]);
                            r_oitem.end_of_text <= (r_nd == 5'd1) && (r_fcnt == '0);
                            r_nd <= r_nd - 1'b1;
                            if ((r_nd == 5'd1) && (r_fcnt == '0)) begin
                                r_state <= S_IDLE;
                                r_int <= '0; r_infrac <= 1'b0; r_num <= '0;
                                r_den <= {{(FB-1){1'b0}}, 1'b1};
                                r_fcnt <= '0; r_ovf <= 1'b0;
                            end
                        end else begin
                            r_oitem.text_char   <= rstd_pkg::ChDot;
                            r_oitem.end_of_text <= (r_num == '0);
                            r_nf <= '0;
                            r_j  <= '0;
                            r_t  <= '0;
                            r_q  <= '0;
                            if (r_num == '0) begin
                                r_state <= S_IDLE;
                                r_int <= '0; r_infrac <= 1'b0;
                                r_den <= {{(FB-1){1'b0}}, 1'b1};
                                r_fcnt <= '0; r_ovf <= 1'b0;
                            end else begin
                                r_state <= S_FDIV;
                            end
                        end
                    end
                end
                // One fraction digit: ten add-and-reduce steps.
                S_FDIV: begin
                    r_t <= w_tnext;
                    if (w_tsum >= {1'b0, r_den}) begin
                        r_q <= r_q + 4'd1;
                    end
                    r_j <= r_j + 4'd1;
                    if (r_j == 4'd9) begin
                        r_state <= S_FOUT;
                    end
                end
                // Emit the fraction digit.
                S_FOUT: begin
                    if (w_out_free) begin
                        r_oitem.overflow  <= r_ovf;
                        r_oitem.text_char <= rstd_pkg::ChZero + 8'(r_q);
                        r_num <= r_t[FB-1:0];
                        r_nf  <= r_nf + 1'b1;
                        r_j <= '0; r_t <= '0; r_q <= '0;
                        if (r_t[FB-1:0] == '0 ||
                            r_nf == rstd_pkg::OcntBits'(rstd_pkg::FracOutDigits-1)) begin
                            r_oitem.end_of_text <= 1'b1;
                            r_state <= S_IDLE;
                            r_int <= '0; r_infrac <= 1'b0; r_num <= '0;
                            r_den <= {{(FB-1){1'b0}}, 1'b1};
                            r_fcnt <= '0; r_ovf <= 1'b0;
                        end else begin
                            r_oitem.end_of_text <= 1'b0;
                            r_state <= S_FDIV;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/radix_string_to_decimal_text_core.sv -----
// Each character passes through the back part's take and update states; the last
// character is followed by the integer digits, then, when fraction digits were kept,
// the point and fraction digits; a new character is taken only when idle.
// Reset: synchronous, active low; clears the queue, number state and radix 10.
// ============================================================================
// Radix string to decimal text: top level
// Front part, item queue and back part, plus the radix register.
// ============================================================================
`default_nettype none

module radix_string_to_decimal_text_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire rstd_pkg::t_in_item  i_item,
    output logic                     o_stall,
    output logic                     o_valid,
    output rstd_pkg::t_out_item      o_item,
    input  wire logic                i_stall,
    input  wire logic                i_cfg_valid,
    input  wire logic [5:0]          i_cfg_data,
    output logic                     o_cfg_ready
);

    logic           w_cmd_valid, w_cmd_take;
    rstd_pkg::t_cmd w_cmd;
    logic [5:0]     r_base;

    assign o_cfg_ready = 1'b1;

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= rstd_pkg::BaseReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data;
        end
    end

    rstd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_item, .o_stall,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    rstd_back u_back (
        .i_clk, .i_rst_n, .i_base(r_base),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .o_valid, .o_item, .i_stall
    );

endmodule

`default_nettype wire

// ----- rtl/rstd_checker.sv -----
// ============================================================================
// Radix string to decimal text: port checker
// Watches the top level's ports over time.
// ============================================================================
`default_nettype none

module rstd_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire rstd_pkg::t_out_item o_item,
    input wire logic                i_stall
);

    // A stalled result item holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed under stall");

    // Every character is a decimal digit or a point.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.text_char == rstd_pkg::ChDot) ||
            (o_item.text_char >= rstd_pkg::ChZero && o_item.text_char <= rstd_pkg::ChNine))
        else $error("bad output character");

    // Overflow is constant within one text.
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_item.end_of_text ##1 o_valid |->
            o_item.overflow == $past(o_item.overflow))
        else $error("overflow changed within text");

    // No valid output right out of reset.
    a_rst: assert property (@(posedge i_clk) !$past(i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

endmodule

bind radix_string_to_decimal_text_core rstd_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .o_item, .i_stall
);

`default_nettype wire
